@@ sv/msc_pkg.sv @@
// Package: widths, edge codes and the case-to-segment tables of the contour unit.
`timescale 1ns / 1ps
package msc_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int FRACTION_BITS   = 8;
    localparam int COORD_W         = 19;
    localparam int REG_W           = 11;
    localparam int ROW_W           = 10;
    localparam int ROW_LIMIT       = 1024;
    localparam int DEF_MAX_ROW_LEN = 1024;
    localparam int CFG_ADDR_W      = 2;
    localparam int OUT_TDATA_W     = 80;

    typedef logic [1:0] t_edge;
    localparam t_edge SIDE_TOP    = 2'd0;
    localparam t_edge SIDE_RIGHT  = 2'd1;
    localparam t_edge SIDE_BOTTOM = 2'd2;
    localparam t_edge SIDE_LEFT   = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_ROW_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD  = 2'd2;

    localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RST = 16'sd205;

    // number of segments per corner case
    localparam logic [1:0] SEG_COUNT [16] = '{
        2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1,
        2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0
    };

    // {seg1 stop, seg1 start, seg0 stop, seg0 start}, two bits each
    localparam logic [7:0] SEG_EDGES [16] = '{
        8'b00_00_00_00, 8'b00_00_10_11, 8'b00_00_01_10, 8'b00_00_01_11,
        8'b00_00_01_00, 8'b01_10_11_00, 8'b00_00_10_00, 8'b00_00_11_00,
        8'b00_00_00_11, 8'b00_00_00_10, 8'b00_11_01_10, 8'b00_00_01_00,
        8'b00_00_11_01, 8'b00_00_10_01, 8'b00_00_10_11, 8'b00_00_00_00
    };

    function automatic t_edge seg_edge(input logic [3:0] cs, input logic k, input logic j);
        logic [7:0] e;
        e = SEG_EDGES[cs];
        case ({k, j})
            2'b00:   seg_edge = e[1:0];
            2'b01:   seg_edge = e[3:2];
            2'b10:   seg_edge = e[5:4];
            default: seg_edge = e[7:6];
        endcase
    endfunction

endpackage

@@ sv/marching_squares_contour_unit.sv @@
// Top level: streaming marching-squares isoline extractor with a line store.
//
//  channel    | direction | handshake                    | payload
//  s_axis     | in        | i_s_axis_tvalid/o_..._tready | sample
//  m_axis     | out       | o_m_axis_tvalid/i_..._tready | start_x,start_y,stop_x,stop_y; tlast
//  cfg        | in        | i_cfg_valid/o_cfg_ready      | register index, data
//
// An item that closes no segment passes only the accept and look-up states; each
// segment adds a setup and a pass of the serial edge divider per endpoint, then a load.
// The line store is read as a sample is accepted and written back in the look-up state.
// Reset clears counters and neighbor samples; the line store is not cleared.
// A stalled output holds its segment; a following item proceeds until it
// needs the output register. Configuration is taken only between items.
`timescale 1ns / 1ps
module marching_squares_contour_unit #(
    parameter int MAX_ROW_LENGTH = msc_pkg::DEF_MAX_ROW_LEN
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [msc_pkg::SAMPLE_BITS-1:0]     i_s_axis_tdata,   // [15:0] sample
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [18:0] start_x, [37:19] start_y, [56:38] stop_x, [75:57] stop_y, [79:76] zero
    output logic [msc_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                                o_m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [msc_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [msc_pkg::SAMPLE_BITS-1:0]     i_cfg_data
);
    import msc_pkg::*;

    localparam int CW = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
    localparam int EW = (CW + 1 > REG_W) ? CW + 1 : REG_W;
    localparam int DW = SAMPLE_BITS + 1;
    localparam int KW = $clog2(FRACTION_BITS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOOK  = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;

    localparam logic [1:0] FR_DIV  = 2'd0;
    localparam logic [1:0] FR_ZERO = 2'd1;
    localparam logic [1:0] FR_ONE  = 2'd2;

    logic [SAMPLE_BITS-1:0] r_mem [MAX_ROW_LENGTH];
    logic [SAMPLE_BITS-1:0] r_rd;

    logic [2:0]                    r_state;
    logic [REG_W-1:0]              r_row_length, r_row_count;
    logic signed [SAMPLE_BITS-1:0] r_thr;
    logic signed [SAMPLE_BITS-1:0] r_s, r_left, r_left_below;
    logic signed [SAMPLE_BITS-1:0] r_tl, r_tr, r_br, r_bl;
    logic [CW-1:0]                 r_col, r_cx;
    logic [ROW_W-1:0]              r_row, r_cy;
    logic [3:0]                    r_case;
    logic                          r_k, r_j;
    t_edge                         r_edge;
    logic [1:0]                    r_mode;
    logic [DW-1:0]                 r_den;
    logic [DW:0]                   r_rem;
    logic [FRACTION_BITS-1:0]      r_q;
    logic [KW-1:0]                 r_cnt;
    logic [COORD_W-1:0]            r_sx, r_sy, r_ex, r_ey;
    logic                          r_m_valid, r_m_last;
    logic [COORD_W-1:0]            r_o_sx, r_o_sy, r_o_ex, r_o_ey;

    // line store: registered read, one write port
    logic s_accept;
    logic mem_we;
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign mem_we   = (r_state == ST_LOOK);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_col] <= r_s;
        end
        r_rd <= r_mem[r_col];
    end

    // cell corners and case
    logic signed [SAMPLE_BITS-1:0] above;
    logic [3:0]  cs;
    logic        cell_ok;
    logic [EW-1:0] len;
    logic [REG_W-1:0] rows;
    always_comb begin
        above = r_rd;
        cs = {r_left > r_thr, r_s > r_thr, above > r_thr, r_left_below > r_thr};
        cell_ok = (r_row != '0) && (r_col != '0);
        len = EW'(r_row_length);
        if (len < EW'(2)) len = EW'(2);
        if (len > EW'(MAX_ROW_LENGTH)) len = EW'(MAX_ROW_LENGTH);
        rows = r_row_count;
        if (rows < REG_W'(2)) rows = REG_W'(2);
        if (rows > REG_W'(ROW_LIMIT)) rows = REG_W'(ROW_LIMIT);
    end

    // edge setup
    t_edge e_cur;
    logic signed [SAMPLE_BITS-1:0] v1, v2;
    logic signed [DW-1:0] num, den, num_n, den_n;
    always_comb begin
        e_cur = seg_edge(r_case, r_k, r_j);
        case (e_cur)
            SIDE_TOP:    begin v1 = r_tl; v2 = r_tr; end
            SIDE_RIGHT:  begin v1 = r_tr; v2 = r_br; end
            SIDE_BOTTOM: begin v1 = r_br; v2 = r_bl; end
            default:     begin v1 = r_bl; v2 = r_tl; end
        endcase
        num = DW'(r_thr) - DW'(v1);
        den = DW'(v2) - DW'(v1);
        if (den < 0) begin
            num_n = -num;
            den_n = -den;
        end else begin
            num_n = num;
            den_n = den;
        end
    end

    // one restoring step, then the endpoint from the finished quotient
    logic [DW:0]              rem2;
    logic                     qbit;
    logic [FRACTION_BITS-1:0] q_next;
    logic [FRACTION_BITS:0]   frac;
    logic [COORD_W-1:0]       x0, x1, y0, y1, f, px, py;
    always_comb begin
        rem2 = {r_rem[DW-1:0], 1'b0};
        qbit = (rem2 >= {1'b0, r_den});
        q_next = {r_q[FRACTION_BITS-2:0], qbit};
        case (r_mode)
            FR_ZERO: frac = '0;
            FR_ONE:  frac = {1'b1, {FRACTION_BITS{1'b0}}};
            default: frac = {1'b0, q_next};
        endcase
        x0 = COORD_W'(r_cx) << FRACTION_BITS;
        x1 = (COORD_W'(r_cx) + COORD_W'(1)) << FRACTION_BITS;
        y0 = COORD_W'(r_cy) << FRACTION_BITS;
        y1 = (COORD_W'(r_cy) + COORD_W'(1)) << FRACTION_BITS;
        f  = COORD_W'(frac);
        case (r_edge)
            SIDE_TOP:    begin px = x0 + f; py = y1;     end
            SIDE_RIGHT:  begin px = x1;     py = y1 - f; end
            SIDE_BOTTOM: begin px = x1 - f; py = y0;     end
            default:     begin px = x0;     py = y0 + f; end
        endcase
    end

    logic out_free;
    assign out_free = !r_m_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_row_length <= REG_W'(1024);
            r_row_count  <= REG_W'(1024);
            r_thr        <= THRESHOLD_RST;
            r_left       <= '0;
            r_left_below <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_addr)
                    REG_ROW_LENGTH: r_row_length <= i_cfg_data[REG_W-1:0];
                    REG_ROW_COUNT:  r_row_count  <= i_cfg_data[REG_W-1:0];
                    REG_THRESHOLD:  r_thr        <= i_cfg_data;
                    default: ;
                endcase
            end
            // drop the item on handshake unless a new one is loaded this cycle
            if (r_m_valid && i_m_axis_tready && !(r_state == ST_LOAD && out_free)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        r_s     <= i_s_axis_tdata;
                        r_state <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    r_tl <= r_left; r_tr <= r_s; r_br <= above; r_bl <= r_left_below;
                    r_cx <= r_col - CW'(1);
                    r_cy <= r_row - ROW_W'(1);
                    r_case <= cs;
                    r_k <= 1'b0;
                    r_j <= 1'b0;
                    r_left_below <= above;
                    r_left <= r_s;
                    if (EW'(r_col) + EW'(1) >= len) begin
                        r_col <= '0;
                        if (REG_W'(r_row) + REG_W'(1) >= rows) r_row <= '0;
                        else r_row <= r_row + ROW_W'(1);
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                    r_state <= (cell_ok && SEG_COUNT[cs] != 2'd0) ? ST_SETUP : ST_IDLE;
                end
                ST_SETUP: begin
                    r_edge <= e_cur;
                    r_den  <= den_n;
                    r_q    <= '0;
                    r_cnt  <= '0;
                    if (den_n == '0 || num_n <= 0) begin
                        r_mode <= FR_ZERO;
                        r_rem  <= '0;
                    end else if (num_n >= den_n) begin
                        r_mode <= FR_ONE;
                        r_rem  <= '0;
                    end else begin
                        r_mode <= FR_DIV;
                        r_rem  <= {1'b0, num_n};
                    end
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= qbit ? rem2 - {1'b0, r_den} : rem2;
                    r_q   <= q_next;
                    r_cnt <= r_cnt + KW'(1);
                    if (r_cnt == KW'(FRACTION_BITS - 1)) begin
                        if (!r_j) begin
                            r_sx <= px; r_sy <= py;
                            r_j <= 1'b1;
                            r_state <= ST_SETUP;
                        end else begin
                            r_ex <= px; r_ey <= py;
                            r_state <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_o_sx <= r_sx; r_o_sy <= r_sy;
                        r_o_ex <= r_ex; r_o_ey <= r_ey;
                        r_m_last <= r_k || (SEG_COUNT[r_case] == 2'd1);
                        if (!r_k && SEG_COUNT[r_case] == 2'd2) begin
                            r_k <= 1'b1;
                            r_j <= 1'b0;
                            r_state <= ST_SETUP;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tlast  = r_m_last;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - 4 * COORD_W){1'b0}},
                              r_o_ey, r_o_ex, r_o_sy, r_o_sx};

endmodule
